>>> design/bnpg_pkg.sv
// bnpg_pkg: shared widths, constants, phase codes and control structs
// for the buzzer note pulse generator; no dependencies
package bnpg_pkg;

    localparam int FREQ_W = 16;
    localparam int DUR_W  = 16;
    localparam int GAP_W  = 16;
    localparam int PER_W  = 20;
    localparam int HALF_W = 19;
    localparam int CYC_W  = 23;
    localparam int TMR_W  = 26;
    localparam int DIV_W  = 26;
    localparam int CNT_W  = 5;
    localparam int PH_W   = 3;
    localparam int PDATA_W = 32;

    localparam int DIV1_ITER = HALF_W;
    localparam int DIV2_ITER = DIV_W;

    localparam logic [GAP_W-1:0] GAP_RESET     = 16'd2000;
    localparam logic [DIV_W-1:0] HALF_NUM      = 26'd500000;
    localparam logic [TMR_W-1:0] MS_TO_US      = 26'd1000;
    localparam logic [DIV_W-1:0] DIV1_DIVIDEND = HALF_NUM << (DIV_W - DIV1_ITER);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PH_W-1:0] PH_HIGH = 3'd1;
    localparam logic [PH_W-1:0] PH_LOW  = 3'd2;
    localparam logic [PH_W-1:0] PH_REST = 3'd3;
    localparam logic [PH_W-1:0] PH_GAP  = 3'd4;

    typedef struct packed {
        logic step;
        logic div1_start;
        logic div_step;
        logic div2_start;
        logic finish;
    } bnpg_cmd_t;

    typedef struct packed {
        logic needs_div;
        logic div_last;
    } bnpg_status_t;

endpackage

>>> design/buzzer_note_pulse_generator_core.sv
// a tick, a rejected load or a rest gives its registered result in the cycle after acceptance
// a sounded note load runs 19 + 26 steps of the shared restoring divider
// (one quotient bit per cycle) plus setup and finish; the next item is taken after that
// throughput: one tick per cycle while results are taken
// reset: rst_n is asynchronous, active low; phase goes idle, timers clear, gap register = 2000
module buzzer_note_pulse_generator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [bnpg_pkg::FREQ_W-1:0]         note_freq_hz,
    input  logic [bnpg_pkg::DUR_W-1:0]          note_duration_ms,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pin_level,
    output logic                                busy_res,
    output logic                                load_rejected,
    output logic                                note_done,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [bnpg_pkg::PDATA_W-1:0]        pwdata,
    output logic [bnpg_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import bnpg_pkg::*;

    bnpg_cmd_t        cmd;
    bnpg_status_t     status;
    logic             cfg_we;
    logic [GAP_W-1:0] gap_value;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? PDATA_W'(gap_value) : '0;

    bnpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bnpg_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .opcode           (opcode),
        .note_freq_hz     (note_freq_hz),
        .note_duration_ms (note_duration_ms),
        .cfg_we           (cfg_we),
        .cfg_wdata        (pwdata[GAP_W-1:0]),
        .gap_value        (gap_value),
        .pin_level        (pin_level),
        .busy_res         (busy_res),
        .load_rejected    (load_rejected),
        .note_done        (note_done)
    );

endmodule

>>> design/bnpg_dp.sv
// bnpg_dp: note state, tick timers, shared restoring divider,
// gap register and result registers; depends on bnpg_pkg
module bnpg_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bnpg_pkg::bnpg_cmd_t               cmd,
    output bnpg_pkg::bnpg_status_t            status,
    input  logic                              opcode,
    input  logic [bnpg_pkg::FREQ_W-1:0]       note_freq_hz,
    input  logic [bnpg_pkg::DUR_W-1:0]        note_duration_ms,
    input  logic                              cfg_we,
    input  logic [bnpg_pkg::GAP_W-1:0]        cfg_wdata,
    output logic [bnpg_pkg::GAP_W-1:0]        gap_value,
    output logic                              pin_level,
    output logic                              busy_res,
    output logic                              load_rejected,
    output logic                              note_done
);
    import bnpg_pkg::*;

    logic [GAP_W-1:0]  gap_reg;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [PER_W-1:0]  pulse_reg, pulse_next;
    logic [PER_W-1:0]  low_reg, low_next;
    logic [CYC_W-1:0]  cycles_reg, cycles_next;
    logic [TMR_W-1:0]  timer_reg, timer_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [PER_W-1:0]  rem_reg, rem_next;
    logic [PER_W-1:0]  dvsr_reg, dvsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TMR_W-1:0]  prod_reg, prod_next;
    logic              pin_reg, busy_reg, rej_reg, done_reg;
    logic              rej_c, done_c;

    logic [TMR_W-1:0]  dur_us;
    logic [PER_W:0]    trial;
    logic [PER_W-1:0]  period;
    logic [PER_W-1:0]  pulse_calc;
    logic [CYC_W-1:0]  quot_cycles;

    assign dur_us      = TMR_W'(note_duration_ms) * MS_TO_US;
    assign trial       = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dvsr_reg};
    assign period      = {quo_reg[HALF_W-1:0], 1'b0};
    assign pulse_calc  = period >> 3;
    assign quot_cycles = quo_reg[CYC_W-1:0];

    assign status.needs_div = (opcode == OP_LOAD) && (phase_reg == PH_IDLE)
                              && (note_freq_hz != '0);
    assign status.div_last  = (cnt_reg == '0);

    always_comb
    begin
        logic [TMR_W-1:0] t_dec;
        logic [CYC_W-1:0] c_dec;
        phase_next  = phase_reg;
        pulse_next  = pulse_reg;
        low_next    = low_reg;
        cycles_next = cycles_reg;
        timer_next  = timer_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvsr_next   = dvsr_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        rej_c       = 1'b0;
        done_c      = 1'b0;
        t_dec       = (timer_reg == '0) ? '0 : timer_reg - 1'b1;
        c_dec       = (cycles_reg == '0) ? '0 : cycles_reg - 1'b1;

        if (cmd.step)
        begin
            if (opcode == OP_LOAD)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej_c = 1'b1;
                end
                else
                begin
                    // rest: frequency of zero
                    timer_next = dur_us;
                    if (dur_us == '0)
                        done_c = 1'b1;
                    else
                        phase_next = PH_REST;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                timer_next = t_dec;
                if (t_dec == '0)
                begin
                    case (phase_reg)
                        PH_HIGH:
                        begin
                            phase_next = PH_LOW;
                            timer_next = TMR_W'(low_reg);
                        end
                        PH_LOW:
                        begin
                            cycles_next = c_dec;
                            if (c_dec != '0)
                            begin
                                phase_next = PH_HIGH;
                                timer_next = TMR_W'(pulse_reg);
                            end
                            else if (gap_reg == '0)
                            begin
                                phase_next = PH_IDLE;
                                timer_next = '0;
                                done_c     = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_GAP;
                                timer_next = TMR_W'(gap_reg);
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            done_c     = 1'b1;
                        end
                    endcase
                end
            end
        end

        if (cmd.div1_start)
        begin
            quo_next  = DIV1_DIVIDEND;
            rem_next  = '0;
            dvsr_next = PER_W'(note_freq_hz);
            cnt_next  = CNT_W'(DIV1_ITER - 1);
            prod_next = dur_us;
        end

        if (cmd.div_step)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[PER_W])
            begin
                rem_next = trial[PER_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[PER_W-2:0], quo_reg[DIV_W-1]};
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
        end

        if (cmd.div2_start)
        begin
            pulse_next = pulse_calc;
            low_next   = period - pulse_calc;
            dvsr_next  = period;
            quo_next   = prod_reg;
            rem_next   = '0;
            cnt_next   = CNT_W'(DIV2_ITER - 1);
        end

        if (cmd.finish)
        begin
            cycles_next = quot_cycles;
            if (quot_cycles != '0)
            begin
                phase_next = PH_HIGH;
                timer_next = TMR_W'(pulse_reg);
            end
            else if (gap_reg == '0)
            begin
                phase_next = PH_IDLE;
                timer_next = '0;
                done_c     = 1'b1;
            end
            else
            begin
                phase_next = PH_GAP;
                timer_next = TMR_W'(gap_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= GAP_RESET;
            phase_reg  <= PH_IDLE;
            pulse_reg  <= '0;
            low_reg    <= '0;
            cycles_reg <= '0;
            timer_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                gap_reg <= cfg_wdata;
            phase_reg  <= phase_next;
            pulse_reg  <= pulse_next;
            low_reg    <= low_next;
            cycles_reg <= cycles_next;
            timer_reg  <= timer_next;
        end
    end

    // divider and result payload
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        if (cmd.step || cmd.finish)
        begin
            pin_reg  <= (phase_next == PH_HIGH);
            busy_reg <= (phase_next != PH_IDLE);
            rej_reg  <= rej_c;
            done_reg <= done_c;
        end
    end

    assign gap_value     = gap_reg;
    assign pin_level     = pin_reg;
    assign busy_res      = busy_reg;
    assign load_rejected = rej_reg;
    assign note_done     = done_reg;

endmodule

>>> design/bnpg_ctrl.sv
// bnpg_ctrl: handshake control and load sequencing state machine
// depends on bnpg_pkg
module bnpg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  bnpg_pkg::bnpg_status_t status,
    output bnpg_pkg::bnpg_cmd_t    cmd
);
    import bnpg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV1   = 3'd1;
    localparam logic [2:0] S_SETUP2 = 3'd2;
    localparam logic [2:0] S_DIV2   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.needs_div)
                    begin
                        cmd.div1_start = 1'b1;
                        state_next     = S_DIV1;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            S_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_SETUP2;
            end
            S_SETUP2:
            begin
                cmd.div2_start = 1'b1;
                state_next     = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.step || cmd.finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/bnpg_checker.sv
// bnpg_checker: port-level assertions on result transactions
// bound to buzzer_note_pulse_generator_core
module bnpg_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic pin_level,
    input logic busy_res,
    input logic load_rejected,
    input logic note_done
);

    // a rejected load leaves the running note in place
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && load_rejected |-> busy_res && !note_done)
        else $error("rejected load without a running note");

    // a finished note leaves the pin low and the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && note_done |-> !busy_res && !pin_level)
        else $error("note done while still busy or driving");

    // the pin only drives while a note runs
    a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pin_level |-> busy_res)
        else $error("pin high while idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pin_level) && $stable(busy_res)
            && $stable(load_rejected) && $stable(note_done))
        else $error("stalled result transaction changed");

endmodule

bind buzzer_note_pulse_generator_core bnpg_checker u_bnpg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pin_level     (pin_level),
    .busy_res      (busy_res),
    .load_rejected (load_rejected),
    .note_done     (note_done)
);
